// File: design/rffc_pkg.sv
// ----------------------------------------------------------------------------
// rffc_pkg: shared types and constants of the rgb frame fade controller
// Header codes, window sizing, colour level struct and fade phase encoding.
// ----------------------------------------------------------------------------
package rffc_pkg;

  // number of received bytes delivered with every tick
  localparam int unsigned InBytes = 9;
  // default number of scanned start positions
  localparam int unsigned WindowBytesDef = 9;
  // bytes a header and its colour payload span from the start position
  localparam int unsigned FrameSpan = 7;

  // frame header bytes
  localparam logic [7:0] HdrSync = 8'hFF;
  localparam logic [7:0] HdrId   = 8'h47;
  localparam logic [7:0] HdrPad  = 8'h00;

  // frame kind byte that follows the header
  localparam logic [7:0] KindColour = 8'h00;
  localparam logic [7:0] KindFade   = 8'h01;

  // full and empty duty values
  localparam logic [7:0] LevelMax = 8'hFF;
  localparam logic [7:0] LevelMin = 8'h00;

  // colour levels of the three channels
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // outcome of the header scan
  typedef struct packed {
    logic colour;
    rgb_t level;
  } match_t;

  // colour wheel fade phases
  typedef enum logic [6:0] {
    PH_INIT       = 7'b0000001,
    PH_RED_UP     = 7'b0000010,
    PH_BLUE_DOWN  = 7'b0000100,
    PH_GREEN_UP   = 7'b0001000,
    PH_RED_DOWN   = 7'b0010000,
    PH_BLUE_UP    = 7'b0100000,
    PH_GREEN_DOWN = 7'b1000000
  } fade_phase_e;

endpackage

// File: design/rffc_match.sv
// ----------------------------------------------------------------------------
// rffc_match: header scan over the received window
// Finds the first fixed-colour or fade header and extracts the colour bytes.
// ----------------------------------------------------------------------------
module rffc_match import rffc_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  logic [InBytes-1:0][7:0] bytes_i,
  output match_t                  match_o
);

  localparam int unsigned SpanLen = WINDOW_BYTES + FrameSpan - 1;

  logic [SpanLen-1:0][7:0] pad;

  // positions past the window or past the received bytes read as zero
  for (genvar k = 0; k < SpanLen; k++) begin : g_pad
    if (k < WINDOW_BYTES && k < InBytes) begin : g_byte
      assign pad[k] = bytes_i[k];
    end else begin : g_zero
      assign pad[k] = '0;
    end
  end

  // first header with a known kind wins, unknown kinds keep scanning
  always_comb begin
    logic found;
    found   = 1'b0;
    match_o = '0;
    for (int p = 0; p < WINDOW_BYTES; p++) begin
      if (!found && pad[p] == HdrSync && pad[p+1] == HdrId && pad[p+2] == HdrPad) begin
        if (pad[p+3] == KindColour) begin
          found               = 1'b1;
          match_o.colour      = 1'b1;
          match_o.level.red   = pad[p+4];
          match_o.level.green = pad[p+5];
          match_o.level.blue  = pad[p+6];
        end else if (pad[p+3] == KindFade) begin
          found = 1'b1;
        end
      end
    end
  end

endmodule

// File: design/rffc_fade.sv
// ----------------------------------------------------------------------------
// rffc_fade: colour level state and seven-phase colour wheel fade
// Loads a fixed colour or takes one fade step on every processed tick.
// ----------------------------------------------------------------------------
module rffc_fade import rffc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  match_t match_i,
  output rgb_t   level_o
);

  rgb_t        level_q, level_d;
  fade_phase_e phase_q, phase_d;

  // next levels and phase: colour load or one fade step
  always_comb begin
    level_d = level_q;
    phase_d = phase_q;
    if (match_i.colour) begin
      level_d = match_i.level;
      phase_d = PH_INIT;
    end else begin
      unique case (phase_q)
        PH_INIT: begin
          level_d.red   = LevelMin;
          level_d.green = LevelMin;
          level_d.blue  = LevelMax;
          phase_d       = PH_RED_UP;
        end
        PH_RED_UP: begin
          level_d.red = level_q.red + 8'd1;
          if (level_d.red == LevelMax) phase_d = PH_BLUE_DOWN;
        end
        PH_BLUE_DOWN: begin
          level_d.blue = level_q.blue - 8'd1;
          if (level_d.blue == LevelMin) phase_d = PH_GREEN_UP;
        end
        PH_GREEN_UP: begin
          level_d.green = level_q.green + 8'd1;
          if (level_d.green == LevelMax) phase_d = PH_RED_DOWN;
        end
        PH_RED_DOWN: begin
          level_d.red = level_q.red - 8'd1;
          if (level_d.red == LevelMin) phase_d = PH_BLUE_UP;
        end
        PH_BLUE_UP: begin
          level_d.blue = level_q.blue + 8'd1;
          if (level_d.blue == LevelMax) phase_d = PH_GREEN_DOWN;
        end
        PH_GREEN_DOWN: begin
          level_d.green = level_q.green - 8'd1;
          if (level_d.green == LevelMin) phase_d = PH_INIT;
        end
        default: begin
          phase_d = PH_INIT;
        end
      endcase
    end
  end

  // state registers, advanced once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      phase_q <= PH_INIT;
    end else if (step_i) begin
      level_q <= level_d;
      phase_q <= phase_d;
    end
  end

  assign level_o = level_d;

`ifndef ASSERT_OFF
  // phase register never leaves the one-hot encoding
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("fade phase not one-hot");

  // a colour frame restarts the wheel and latches its colour
  a_colour_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && match_i.colour |=> phase_q == PH_INIT && level_q == $past(match_i.level))
    else $error("colour frame did not restart the fade");

  // idle cycles leave the levels untouched
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(level_q) && $stable(phase_q))
    else $error("fade state moved without a step");
`endif

endmodule

// File: design/rgb_frame_fade_controller_core.sv
// ----------------------------------------------------------------------------
// rgb_frame_fade_controller_core: frame-driven rgb duty controller
// Scans each tick's received bytes for colour headers and drives duty values.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: byte0..byte8, one tick's received window
//  m_axis   | out       | tdata: duty_red, duty_green, duty_blue
//           |           | tuser: colour_frame_seen
//
// one transaction per cycle sustained while m_axis_tready is high; an accepted
// transaction loads the input register, then passes the scan and fade step into
// the result register, from which the duty transaction is offered.
// rst_ni clears the valid flags, the fade levels to zero and the fade phase.
// a stalled result blocks the input register only once it is also full.
// ----------------------------------------------------------------------------
module rgb_frame_fade_controller_core import rffc_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // byte0 .. byte8, 8 bits each
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // duty_red, duty_green, duty_blue
  output logic [0:0]  m_axis_tuser    // colour_frame_seen
);

  logic                   in_valid_q, in_valid_d;
  logic [InBytes-1:0][7:0] in_bytes_q;
  logic                   out_valid_q, out_valid_d;
  rgb_t                   out_level_q;
  logic                   out_colour_q;

  logic   s_accept;
  logic   out_free;
  logic   advance;
  match_t match;
  rgb_t   level_next;

  // handshake: result register frees the input register
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_bytes_q <= s_axis_tdata;
    end
  end

  // header scan
  rffc_match #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_match (
    .bytes_i(in_bytes_q),
    .match_o(match)
  );

  // colour state and fade step
  rffc_fade u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .match_i(match),
    .level_o(level_next)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q  <= level_next;
      out_colour_q <= match.colour;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_level_q.blue, out_level_q.green, out_level_q.red};
  assign m_axis_tuser  = out_colour_q;

`ifndef ASSERT_OFF
  // an empty input register always takes a new transaction
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input refused while input register empty");

  // a processed transaction always lands in the result register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed transaction lost");

  // a stalled result holds its payload until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("stalled result changed");
`endif

endmodule
